[hdl/tms_pkg.sv]
// package for the triangle midpoint subdivider: field widths, vertex type, limits
// no dependencies
package tms_pkg;

  localparam int CoordWidth   = 16;
  localparam int UnitFracBits = 14;
  localparam int NumField     = 11;
  localparam int SumWidth     = CoordWidth + 1;
  // magnitude of a two-field sum, 2^CoordWidth included
  localparam int MagWidth     = SumWidth;
  localparam int LenWidth     = 2 * MagWidth + 2;
  localparam int RadWidth     = LenWidth + 28;
  localparam int RootWidth    = RadWidth / 2;
  localparam int NumWidth     = MagWidth + UnitFracBits + 14 + 1;
  localparam int QuoWidth     = NumWidth;
  localparam int DataWidth    = NumField * CoordWidth;
  localparam int TdataWidth   = ((DataWidth + 7) / 8) * 8;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef coord_t [NumField-1:0] vertex_t;

  localparam logic [QuoWidth-1:0] UnitLim = QuoWidth'((64'd1 << (CoordWidth - 1)) - 64'd1);

endpackage

[hdl/tms_norm.sv]
// vector normalization unit: one shared restoring root/divide step per cycle
// depends on tms_pkg
module tms_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [tms_pkg::SumWidth-1:0] s0_i,
  input  logic signed [tms_pkg::SumWidth-1:0] s1_i,
  input  logic signed [tms_pkg::SumWidth-1:0] s2_i,
  output logic                          done_o,
  output tms_pkg::coord_t               o0_o,
  output tms_pkg::coord_t               o1_o,
  output tms_pkg::coord_t               o2_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQR, ST_ROOT, ST_DIV, ST_DONE
  } state_e;

  localparam int RootSteps = tms_pkg::RootWidth;
  localparam int DivSteps  = tms_pkg::QuoWidth;
  localparam int CntWidth  = $clog2(RootSteps + DivSteps + 1);

  state_e state_q;
  logic [CntWidth-1:0] cnt_q;
  logic [1:0] comp_q;
  logic [2:0] neg_q;
  logic [tms_pkg::MagWidth-1:0] mag_q [3];
  logic [tms_pkg::LenWidth-1:0] len_q;
  logic [tms_pkg::RadWidth-1:0] rad_q;
  logic [tms_pkg::RootWidth+1:0] rem_q;
  logic [tms_pkg::RootWidth-1:0] root_q;
  logic [tms_pkg::NumWidth-1:0] num_q;
  logic [tms_pkg::RootWidth:0] drem_q;
  logic [tms_pkg::QuoWidth-1:0] quo_q;
  tms_pkg::coord_t res_q [3];

  logic [tms_pkg::MagWidth-1:0] m0, m1, m2, mc;
  logic [2*tms_pkg::MagWidth-1:0] sq;
  logic [tms_pkg::RootWidth+1:0] rtrial;
  logic [tms_pkg::RootWidth+1:0] rsub;
  logic [tms_pkg::RootWidth-1:0] root_nx;
  logic [tms_pkg::RootWidth:0] dtrial;
  logic [tms_pkg::QuoWidth-1:0] qsat;
  logic [tms_pkg::NumWidth-1:0] numc;

  assign m0 = tms_pkg::MagWidth'(s0_i < 0 ? -s0_i : s0_i);
  assign m1 = tms_pkg::MagWidth'(s1_i < 0 ? -s1_i : s1_i);
  assign m2 = tms_pkg::MagWidth'(s2_i < 0 ? -s2_i : s2_i);
  assign mc = mag_q[comp_q];
  assign sq = mc * mc;
  assign rtrial = {rem_q[tms_pkg::RootWidth-1:0], rad_q[tms_pkg::RadWidth-1 -: 2]};
  assign rsub = {root_q, 2'b01};
  // root after the current step, final on the last root cycle
  assign root_nx = {root_q[tms_pkg::RootWidth-2:0], rtrial >= rsub};
  assign dtrial = {drem_q[tms_pkg::RootWidth-1:0], num_q[tms_pkg::NumWidth-1]};
  assign qsat = (quo_q > tms_pkg::UnitLim) ? tms_pkg::UnitLim : quo_q;
  // dividend with half-root rounding folded in
  assign numc = ({mc, (tms_pkg::UnitFracBits + 14)'(0)} & tms_pkg::NumWidth'({tms_pkg::NumWidth{1'b1}}))
              + tms_pkg::NumWidth'(root_nx >> 1);

  assign done_o = (state_q == ST_DONE);
  assign o0_o = res_q[0];
  assign o1_o = res_q[1];
  assign o2_o = res_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            mag_q[0] <= m0;
            mag_q[1] <= m1;
            mag_q[2] <= m2;
            neg_q    <= {s2_i < 0, s1_i < 0, s0_i < 0};
            len_q    <= '0;
            comp_q   <= '0;
            if (m0 == '0 && m1 == '0 && m2 == '0) begin
              // zero-length sum gives the zero vector
              res_q[0] <= '0;
              res_q[1] <= '0;
              res_q[2] <= '0;
              state_q  <= ST_DONE;
            end else begin
              state_q <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          // one square per cycle through the shared multiplier
          len_q <= len_q + tms_pkg::LenWidth'(sq);
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_ROOT;
            rem_q   <= '0;
            root_q  <= '0;
            rad_q   <= {len_q + tms_pkg::LenWidth'(sq), 28'd0};
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_ROOT: begin
          // two radicand bits per cycle
          rad_q <= rad_q << 2;
          if (rtrial >= rsub) begin
            rem_q  <= rtrial - rsub;
            root_q <= {root_q[tms_pkg::RootWidth-2:0], 1'b1};
          end else begin
            rem_q  <= rtrial;
            root_q <= {root_q[tms_pkg::RootWidth-2:0], 1'b0};
          end
          if (cnt_q == CntWidth'(RootSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
            drem_q  <= '0;
            quo_q   <= '0;
            num_q   <= numc;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          num_q <= num_q << 1;
          if (dtrial >= {1'b0, root_q}) begin
            drem_q <= dtrial - {1'b0, root_q};
            quo_q  <= {quo_q[tms_pkg::QuoWidth-2:0], 1'b1};
          end else begin
            drem_q <= dtrial;
            quo_q  <= {quo_q[tms_pkg::QuoWidth-2:0], 1'b0};
          end
          if (cnt_q == CntWidth'(DivSteps)) begin
            res_q[comp_q] <= neg_q[comp_q] ? -tms_pkg::CoordWidth'(qsat)
                                           : tms_pkg::CoordWidth'(qsat);
            cnt_q <= '0;
            drem_q <= '0;
            quo_q  <= '0;
            if (comp_q == 2'd2) begin
              state_q <= ST_DONE;
            end else begin
              comp_q <= comp_q + 2'd1;
              num_q  <= ({mag_q[comp_q + 2'd1], (tms_pkg::UnitFracBits + 14)'(0)}
                         & tms_pkg::NumWidth'({tms_pkg::NumWidth{1'b1}}))
                        + tms_pkg::NumWidth'(root_q >> 1);
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/triangle_midpoint_subdivider.sv]
// top level of the triangle midpoint subdivider: corner store, sequencer, output register
// depends on tms_pkg and tms_norm
//
// channel  dir  signals                    word
// s_axis   in   tvalid tready tdata        one corner vertex
// m_axis   out  tvalid tready tdata tlast  one emitted vertex, tlast on the sixth
//
// corner 2 triggers six vertices
// a normalization in tms_norm runs start, three squares, the root steps, the divide
// steps per component and done; a zero-length sum goes straight from start to done
// each midpoint needs two normalizations, normal then tangent, plus an emit
// so the bit-serial root and divider set the throughput of a triangle
// input is held off while a triangle is being emitted; output stalls simply wait
// reset clears the corner count and the sequencer; held corners need no reset
module triangle_midpoint_subdivider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // position_x/y/z, normal_x/y/z, tangent_x/y/z, tex_u, tex_v from bit 0 up
  input  logic [tms_pkg::TdataWidth-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_position_x/y/z, out_normal_x/y/z, out_tangent_x/y/z, out_tex_u, out_tex_v
  output logic [tms_pkg::TdataWidth-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IN, ST_CORNER, ST_NORM_N, ST_NORM_T, ST_MID, ST_WAIT
  } state_e;

  state_e state_q;
  logic [1:0] count_q;
  logic [2:0] vidx_q;
  tms_pkg::vertex_t held_q [3];
  tms_pkg::vertex_t mid_q;
  logic m_valid_q;
  tms_pkg::vertex_t m_data_q;
  logic m_last_q;

  tms_pkg::vertex_t in_v, va, vb;
  logic norm_start;
  logic norm_done;
  tms_pkg::coord_t n0, n1, n2;
  logic signed [tms_pkg::SumWidth-1:0] s0, s1, s2;
  logic out_free;
  logic [1:0] ia, ib;

  assign in_v = s_axis_tdata[tms_pkg::DataWidth-1:0];
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IN);

  // edge endpoints for midpoints 01, 12, 02
  always_comb begin
    case (vidx_q)
      3'd3:    begin ia = 2'd0; ib = 2'd1; end
      3'd4:    begin ia = 2'd1; ib = 2'd2; end
      default: begin ia = 2'd0; ib = 2'd2; end
    endcase
  end
  assign va = held_q[ia];
  assign vb = held_q[ib];

  // vector sums feed the shared normalizer: normal first, then tangent
  always_comb begin
    if (state_q == ST_NORM_T) begin
      s0 = tms_pkg::SumWidth'(va[6]) + tms_pkg::SumWidth'(vb[6]);
      s1 = tms_pkg::SumWidth'(va[7]) + tms_pkg::SumWidth'(vb[7]);
      s2 = tms_pkg::SumWidth'(va[8]) + tms_pkg::SumWidth'(vb[8]);
    end else begin
      s0 = tms_pkg::SumWidth'(va[3]) + tms_pkg::SumWidth'(vb[3]);
      s1 = tms_pkg::SumWidth'(va[4]) + tms_pkg::SumWidth'(vb[4]);
      s2 = tms_pkg::SumWidth'(va[5]) + tms_pkg::SumWidth'(vb[5]);
    end
  end

  logic started_q;
  assign norm_start = (state_q == ST_NORM_N || state_q == ST_NORM_T) && !started_q;

  tms_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .s0_i    (s0),
    .s1_i    (s1),
    .s2_i    (s2),
    .done_o  (norm_done),
    .o0_o    (n0),
    .o1_o    (n1),
    .o2_o    (n2)
  );

  function automatic tms_pkg::coord_t half_sum(tms_pkg::coord_t a, tms_pkg::coord_t b);
    logic signed [tms_pkg::SumWidth-1:0] s;
    s = tms_pkg::SumWidth'(a) + tms_pkg::SumWidth'(b);
    return s[tms_pkg::SumWidth-1:1];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IN;
      count_q   <= '0;
      vidx_q    <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      started_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IN: begin
          if (s_axis_tvalid) begin
            held_q[count_q] <= in_v;
            if (count_q == 2'd2) begin
              count_q <= '0;
              vidx_q  <= '0;
              state_q <= ST_CORNER;
            end else begin
              count_q <= count_q + 2'd1;
            end
          end
        end
        ST_CORNER: begin
          // corners pass through unchanged
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= held_q[vidx_q[1:0]];
            m_last_q  <= 1'b0;
            vidx_q    <= vidx_q + 3'd1;
            if (vidx_q == 3'd2) begin
              state_q <= ST_NORM_N;
            end
          end
        end
        ST_NORM_N: begin
          started_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            mid_q[i] <= half_sum(va[i], vb[i]);
          end
          mid_q[9]  <= half_sum(va[9], vb[9]);
          mid_q[10] <= half_sum(va[10], vb[10]);
          if (norm_done) begin
            mid_q[3]  <= n0;
            mid_q[4]  <= n1;
            mid_q[5]  <= n2;
            started_q <= 1'b0;
            state_q   <= ST_NORM_T;
          end
        end
        ST_NORM_T: begin
          started_q <= 1'b1;
          if (norm_done) begin
            mid_q[6]  <= n0;
            mid_q[7]  <= n1;
            mid_q[8]  <= n2;
            started_q <= 1'b0;
            state_q   <= ST_MID;
          end
        end
        ST_MID: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= mid_q;
            m_last_q  <= (vidx_q == 3'd5);
            vidx_q    <= vidx_q + 3'd1;
            state_q   <= (vidx_q == 3'd5) ? ST_WAIT : ST_NORM_N;
          end
        end
        ST_WAIT: begin
          state_q <= ST_IN;
        end
        default: state_q <= ST_IN;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = tms_pkg::TdataWidth'(m_data_q);

endmodule
